>>> rtl/lpht_pkg.sv
// Shared types and constants of the linear-probing hash table.
package lpht_pkg;

    localparam int KEY_W    = 31;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 7;
    localparam int CFG_W    = 8;

    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 8'd128;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key_value;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_index;
    } t_rsp;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE
    } t_state;

endpackage

>>> rtl/lpht_modulo.sv
// Bit-serial restoring remainder unit: key modulo table size, one key bit per cycle.
module lpht_modulo #(
    parameter int REM_W = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lpht_pkg::KEY_W-1:0] i_dividend,
    input  logic [REM_W-1:0]           i_divisor,
    output logic                       o_done,
    output logic [REM_W-1:0]           o_remainder
);

    localparam int CNT_W = $clog2(lpht_pkg::KEY_W);

    logic                       r_busy;
    logic                       r_done;
    logic [CNT_W-1:0]           r_cnt;
    logic [lpht_pkg::KEY_W-1:0] r_shift;
    logic [REM_W-1:0]           r_rem;
    logic [REM_W:0]             w_trial;
    logic [REM_W-1:0]           n_rem;

    // Bring down the next key bit and subtract the divisor when it fits.
    always_comb begin
        w_trial = {r_rem, r_shift[lpht_pkg::KEY_W-1]};
        if (w_trial >= {1'b0, i_divisor}) begin
            n_rem = REM_W'(w_trial - {1'b0, i_divisor});
        end else begin
            n_rem = w_trial[REM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(lpht_pkg::KEY_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_dividend;
            r_rem   <= '0;
        end else if (r_busy) begin
            r_shift <= {r_shift[lpht_pkg::KEY_W-2:0], 1'b0};
            r_rem   <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

endmodule

>>> rtl/linear_probe_hash_table_core.sv
// Top level of the linear-probing hash table: sequencer, slot memory and ports.
//
//  Channel   | Ports                              | Handshake
//  ----------+------------------------------------+---------------------------------
//  request   | start, busy, i_req                 | beat taken when start && !busy
//  response  | o_strobe, o_rsp                    | one-cycle strobe, no back-pressure
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_data | beat taken when valid && ready
//
// After reset the block runs a clearing pass over all SLOT_COUNT entries of the slot
// memory, one entry per cycle, with busy high; configuration beats are taken all along.
// A request of an unknown kind answers in the next cycle and leaves busy low.
// Any other request first computes the key modulo the live size (one key bit per
// cycle in the remainder subtractor), then reads one slot memory entry per cycle
// along the probe chain, up to the live table size, and checks each slot once its
// registered read returns.
// The strobe rises in the cycle after the deciding probe; the receiver cannot stall.
module linear_probe_hash_table_core #(
    parameter int SLOT_COUNT = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  lpht_pkg::t_req                i_req,
    output logic                          o_strobe,
    output lpht_pkg::t_rsp                o_rsp,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lpht_pkg::CFG_W-1:0]    i_cfg_data
);

    // Slot number width and a width that can also hold the live size itself.
    localparam int IW = $clog2(SLOT_COUNT);
    localparam int SW = IW + 1;

    // Each memory word is {used, key}; the clearing pass zeroes the used bit.
    localparam int MW = lpht_pkg::KEY_W + 1;

    lpht_pkg::t_state               r_state;
    lpht_pkg::t_state               n_state;
    logic [lpht_pkg::CFG_W-1:0]     r_table_size;
    logic [SW-1:0]                  r_size;
    logic [SW-1:0]                  n_size;
    logic [lpht_pkg::KIND_W-1:0]    r_kind;
    logic [lpht_pkg::KEY_W-1:0]     r_key;
    logic [IW-1:0]                  r_clr;

    // Probe pointers: r_addr is the next slot to read, r_issue counts reads sent,
    // r_eval counts slots already rejected.
    logic [IW-1:0]                  r_addr;
    logic [IW-1:0]                  n_addr;
    logic [SW-1:0]                  r_issue;
    logic [SW-1:0]                  r_eval;
    logic                           w_issue;

    // Slot memory with a registered read port.
    logic [MW-1:0]                  r_mem [SLOT_COUNT];
    logic [MW-1:0]                  r_q;
    logic [IW-1:0]                  r_q_slot;
    logic                           r_q_v;
    logic                           w_we;
    logic [IW-1:0]                  w_waddr;
    logic [MW-1:0]                  w_wdata;
    logic                           w_hit;

    // Remainder unit hookup.
    logic                           w_mod_start;
    logic                           w_mod_done;
    logic [SW-1:0]                  w_mod_rem;

    // Response register.
    logic                           w_emit;
    logic [lpht_pkg::STATUS_W-1:0]  w_emit_status;
    logic [IW-1:0]                  w_emit_slot;
    logic                           r_strobe;
    lpht_pkg::t_rsp                 r_rsp;

    // The remainder unit only loads the key in its start cycle and uses the divisor
    // from the next cycle on, when the size captured with the request is in r_size.
    // A configuration beat taken meanwhile therefore only affects later requests.
    lpht_modulo #(
        .REM_W (SW)
    ) u_modulo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_mod_start),
        .i_dividend  (i_req.key_value),
        .i_divisor   (r_size),
        .o_done      (w_mod_done),
        .o_remainder (w_mod_rem)
    );

    // The live size clamps a zero register to one and a large one to SLOT_COUNT.
    // It is captured when a request is taken.
    always_comb begin
        if (r_table_size == '0) begin
            n_size = SW'(1);
        end else if (32'(r_table_size) > SLOT_COUNT) begin
            n_size = SW'(SLOT_COUNT);
        end else begin
            n_size = SW'(r_table_size);
        end
    end

    // Next probe address, wrapping from the last live slot back to slot zero.
    always_comb begin
        if ((SW'(r_addr) + SW'(1)) >= r_size) begin
            n_addr = '0;
        end else begin
            n_addr = r_addr + 1'b1;
        end
    end

    assign w_issue = (r_state == lpht_pkg::S_PROBE) && (r_issue < r_size);

    // An insert wants an empty slot; delete and search want a used slot holding the key.
    always_comb begin
        if (r_kind == lpht_pkg::KIND_INSERT) begin
            w_hit = !r_q[lpht_pkg::KEY_W];
        end else begin
            w_hit = r_q[lpht_pkg::KEY_W] && (r_q[lpht_pkg::KEY_W-1:0] == r_key);
        end
    end

    // Sequencer: next state, memory write and response.
    always_comb begin
        n_state       = r_state;
        w_mod_start   = 1'b0;
        w_we          = 1'b0;
        w_waddr       = r_q_slot;
        w_wdata       = '0;
        w_emit        = 1'b0;
        w_emit_status = lpht_pkg::ST_NOT_FOUND;
        w_emit_slot   = '0;
        case (r_state)
            lpht_pkg::S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                if (r_clr == IW'(SLOT_COUNT - 1)) begin
                    n_state = lpht_pkg::S_IDLE;
                end
            end
            lpht_pkg::S_IDLE: begin
                if (start) begin
                    case (i_req.kind) inside
                        lpht_pkg::KIND_INSERT, lpht_pkg::KIND_DELETE,
                        lpht_pkg::KIND_SEARCH: begin
                            w_mod_start = 1'b1;
                            n_state     = lpht_pkg::S_HASH;
                        end
                        default: begin
                            // Unknown kind: answer not found right away.
                            w_emit = 1'b1;
                        end
                    endcase
                end
            end
            lpht_pkg::S_HASH: begin
                if (w_mod_done) begin
                    n_state = lpht_pkg::S_PROBE;
                end
            end
            lpht_pkg::S_PROBE: begin
                if (r_q_v) begin
                    if (w_hit) begin
                        w_emit      = 1'b1;
                        w_emit_slot = r_q_slot;
                        n_state     = lpht_pkg::S_IDLE;
                        case (r_kind)
                            lpht_pkg::KIND_INSERT: begin
                                w_we          = 1'b1;
                                w_wdata       = {1'b1, r_key};
                                w_emit_status = lpht_pkg::ST_INSERTED;
                            end
                            lpht_pkg::KIND_DELETE: begin
                                w_we          = 1'b1;
                                w_wdata       = '0;
                                w_emit_status = lpht_pkg::ST_DELETED;
                            end
                            default: begin
                                w_emit_status = lpht_pkg::ST_FOUND;
                            end
                        endcase
                    end else if ((r_eval + SW'(1)) == r_size) begin
                        // A full circle without a match.
                        w_emit  = 1'b1;
                        n_state = lpht_pkg::S_IDLE;
                        if (r_kind == lpht_pkg::KIND_INSERT) begin
                            w_emit_status = lpht_pkg::ST_FULL;
                        end else begin
                            w_emit_status = lpht_pkg::ST_NOT_FOUND;
                        end
                    end
                end
            end
            default: begin
                n_state = lpht_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpht_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= lpht_pkg::CFG_SIZE_RESET;
            r_clr        <= '0;
            r_q_v        <= 1'b0;
            r_strobe     <= 1'b0;
            r_issue      <= '0;
            r_eval       <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_table_size <= i_cfg_data;
            end
            if (r_state == lpht_pkg::S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            r_q_v    <= w_issue;
            r_strobe <= w_emit;
            if (r_state == lpht_pkg::S_HASH) begin
                r_issue <= '0;
                r_eval  <= '0;
            end else begin
                if (w_issue) begin
                    r_issue <= r_issue + 1'b1;
                end
                if (r_q_v && (r_state == lpht_pkg::S_PROBE)) begin
                    r_eval <= r_eval + 1'b1;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if ((r_state == lpht_pkg::S_IDLE) && start) begin
            r_kind <= i_req.kind;
            r_key  <= i_req.key_value;
            r_size <= n_size;
        end
        if (r_state == lpht_pkg::S_HASH) begin
            r_addr <= w_mod_rem[IW-1:0];
        end else if (w_issue) begin
            r_addr <= n_addr;
        end
        if (w_issue) begin
            r_q_slot <= r_addr;
        end
        if (w_emit) begin
            r_rsp.status     <= w_emit_status;
            r_rsp.slot_index <= lpht_pkg::SLOT_W'(w_emit_slot);
        end
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_q <= r_mem[r_addr];
    end

    assign busy        = (r_state != lpht_pkg::S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_rsp       = r_rsp;
    assign o_cfg_ready = 1'b1;

`ifndef SYNTHESIS
    // A probed slot always lies inside the live table.
    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lpht_pkg::S_PROBE && r_q_v) |-> (SW'(r_q_slot) < r_size))
        else $error("probe left the live table");

    // Slots are never rejected faster than they are read.
    a_eval_behind_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lpht_pkg::S_PROBE) |-> (r_eval <= r_issue))
        else $error("probe evaluation ran ahead of memory reads");

    // Any answer other than not found comes out of the probe phase.
    a_answer_from_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.status != lpht_pkg::ST_NOT_FOUND)
            |-> ($past(r_state) == lpht_pkg::S_PROBE))
        else $error("probe answer without a probe");

    // The remainder unit finishes only in the hash phase, with a remainder below r_size.
    a_mod_done_in_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_done |-> (r_state == lpht_pkg::S_HASH && w_mod_rem < r_size))
        else $error("remainder finished outside the hash phase or out of range");
`endif

endmodule
